// ----- rtl/akpc_pkg.sv -----
// Shared types and constants of the resistor-ladder keypad decoder.
package akpc_pkg;

  localparam int MAX_KEYS  = 5;
  localparam int KEY_COUNT = 5;
  localparam int SAMPLE_W  = 12;
  localparam int WINDOW_W  = 2 * SAMPLE_W;
  localparam int DEB_W     = 8;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = WINDOW_W;
  localparam int IN_DATA_W = 16;
  localparam int IN_USER_W = 1;
  localparam int OUT_DATA_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KEY1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KEY2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KEY3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KEY4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KEY5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd6;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET [MAX_KEYS] = '{
    {12'd2900, 12'd2500},
    {12'd2300, 12'd1900},
    {12'd1800, 12'd1400},
    {12'd700,  12'd400},
    {12'd1200, 12'd800}
  };
  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET   = 8'd5;
  localparam logic [COUNT_W-1:0] LONG_PRESS_RESET = 16'd100;

  typedef logic [WINDOW_W-1:0] window_arr_t [MAX_KEYS];
  typedef logic [MAX_KEYS-1:0] key_mask_t;

  typedef struct packed {
    logic evt_short;
    logic evt_long;
    logic evt_hold;
  } key_evt_t;

endpackage

// ----- rtl/akpc_window_cmp.sv -----
// Inclusive min/max window compare of the current sample for every key.
module akpc_window_cmp (
  input  logic [akpc_pkg::SAMPLE_W-1:0] sample,
  input  akpc_pkg::window_arr_t         windows,
  output akpc_pkg::key_mask_t           in_window
);
  import akpc_pkg::*;

  always_comb begin
    in_window = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      in_window[k] = (sample >= windows[k][SAMPLE_W-1:0]) &&
                     (sample <= windows[k][WINDOW_W-1:SAMPLE_W]);
    end
  end

endmodule

// ----- rtl/akpc_key_fsm.sv -----
// Press state machine of one key: idle, debounce, pressed and long-pressed.
module akpc_key_fsm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         in_window,
  input  logic [akpc_pkg::DEB_W-1:0]   debounce_ticks,
  input  logic [akpc_pkg::COUNT_W-1:0] long_press_ticks,
  output akpc_pkg::key_evt_t           evt
);
  import akpc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_PRESSED,
    PH_LONG
  } phase_t;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] count, count_next, count_inc;

  assign count_inc = (count == COUNT_MAX) ? COUNT_MAX : count + 1'b1;

  always_comb begin
    phase_next = phase;
    count_next = count;
    evt        = '0;
    case (phase)
      PH_IDLE: begin
        if (in_window) begin
          phase_next = PH_DEBOUNCE;
          count_next = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (in_window) begin
          count_next = count_inc;
          if (count_inc >= {{(COUNT_W-DEB_W){1'b0}}, debounce_ticks}) begin
            phase_next = PH_PRESSED;
          end
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (in_window) begin
          count_next = count_inc;
          if (count_inc >= long_press_ticks) begin
            phase_next = PH_LONG;
          end
        end else begin
          evt.evt_short = 1'b1;
          phase_next    = PH_IDLE;
        end
      end
      default: begin
        evt.evt_hold = 1'b1;
        if (!in_window) begin
          evt.evt_long = 1'b1;
          phase_next   = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
    end else if (step) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

endmodule

// ----- rtl/adc_ladder_key_press_classifier.sv -----
// Top level of the resistor-ladder keypad decoder.
//
// Channel  Direction  Contents
// s_*      in         tuser: sample_valid; tdata: sample_value [11:0], zero pad
// m_*      out        tdata: in_window, short, long, hold masks, 5 bits each
// cfg_*    in         register index and write data, one write per cycle
//
// One poll tick is accepted per clock while s_tready is high; its result is
// registered in the output register, or in the skid register while stalled.
// The key machines and held sample update at the accept. The skid register
// keeps s_tready independent of m_tready; s_tready drops only while it is
// full. Reset is synchronous and restores the default windows and thresholds.
module adc_ladder_key_press_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [akpc_pkg::IN_DATA_W-1:0]  s_tdata,  // sample_value [11:0]
  input  logic [akpc_pkg::IN_USER_W-1:0]  s_tuser,  // sample_valid [0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // in_window_mask, short_event_mask, long_event_mask, hold_event_mask
  output logic [akpc_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [akpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [akpc_pkg::CFG_W-1:0]      cfg_data
);
  import akpc_pkg::*;

  window_arr_t         windows;
  logic [DEB_W-1:0]    debounce_ticks;
  logic [COUNT_W-1:0]  long_press_ticks;
  logic [SAMPLE_W-1:0] held_sample, sample_cur;
  key_mask_t           in_window, short_mask, long_mask, hold_mask;
  key_evt_t            key_evt [KEY_COUNT];
  logic [OUT_DATA_W-1:0] result, skid_data;
  logic                skid_valid;
  logic                accept;

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = !skid_valid;
  assign sample_cur = s_tuser[0] ? s_tdata[SAMPLE_W-1:0] : held_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_KEYS; k++) begin
        windows[k] <= WINDOW_RESET[k];
      end
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_KEY1: windows[0] <= cfg_data;
        REG_WINDOW_KEY2: windows[1] <= cfg_data;
        REG_WINDOW_KEY3: windows[2] <= cfg_data;
        REG_WINDOW_KEY4: windows[3] <= cfg_data;
        REG_WINDOW_KEY5: windows[4] <= cfg_data;
        REG_DEBOUNCE:    debounce_ticks <= cfg_data[DEB_W-1:0];
        REG_LONG_PRESS:  long_press_ticks <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_sample <= '0;
    end else if (accept) begin
      held_sample <= sample_cur;
    end
  end

  akpc_window_cmp u_cmp (
    .sample    (sample_cur),
    .windows   (windows),
    .in_window (in_window)
  );

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    akpc_key_fsm u_fsm (
      .clk              (clk),
      .rst              (rst),
      .step             (accept),
      .in_window        (in_window[k]),
      .debounce_ticks   (debounce_ticks),
      .long_press_ticks (long_press_ticks),
      .evt              (key_evt[k])
    );
  end

  always_comb begin
    short_mask = '0;
    long_mask  = '0;
    hold_mask  = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      short_mask[k] = key_evt[k].evt_short;
      long_mask[k]  = key_evt[k].evt_long;
      hold_mask[k]  = key_evt[k].evt_hold;
    end
  end

  assign result = {{(OUT_DATA_W - 4*MAX_KEYS){1'b0}},
                   hold_mask, long_mask, short_mask, in_window};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
      end else if (accept) begin
        m_tdata <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule
